### design/csv_delimiter_marker_assert.svh
// Assertion macros for the CSV delimiter marker.
`ifndef CSV_DELIMITER_MARKER_ASSERT_SVH
`define CSV_DELIMITER_MARKER_ASSERT_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define CDM_ASSERT_SAME(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define CDM_ASSERT_NEXT(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`else
`define CDM_ASSERT_SAME(label, a, b, msg)
`define CDM_ASSERT_NEXT(label, a, b, msg)
`endif
`endif

### design/csvdm_pkg.sv
// Shared types and constants of the CSV delimiter marker.
package csvdm_pkg;

	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] DELIM_RESET = 8'h2C;
	localparam logic [7:0] QUOTE_RESET = 8'h22;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_DELIMITER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTE_BYTE      = 2'd1;

	// Result queue geometry
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} csvdm_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       record_end;
		logic       field_end;
		logic       escape_quote;
		logic       keep_byte;
		logic       last_out;
	} csvdm_out_t;

	// Quote tracking state carried from byte to byte
	typedef struct packed {
		logic quote_parity;
		logic in_quoted_span;
		logic prior_was_escape;
	} csvdm_state_t;

	// Up to two words pushed into the result queue in one cycle
	typedef struct packed {
		logic [1:0] cnt;
		csvdm_out_t first;
		csvdm_out_t second;
	} csvdm_push_t;

endpackage

### design/csv_delimiter_marker.sv
// Top level of the CSV delimiter marker.
//
// Input channel byte_*: one raw CSV byte per word with an end-of-stream flag,
// taken when byte_valid is high and byte_stall is low.
// Output channel mark_*: one marked byte per word, taken when mark_valid is
// high and mark_stall is low. Each byte is held until the next byte arrives,
// since the marks need one byte of lookahead; a word with end_of_stream set
// releases any held byte and itself, as consecutive output words.
// A released result is queued when the input word releasing it is taken and
// shows on mark_* after earlier words. One input word is taken per cycle while
// byte_stall is low; a stream end with a held byte pushes two output words.
// A four-entry result queue decouples the sides; byte_stall rises once it
// holds more than two words, so a stalled receiver backs up the input side
// without losing anything.
// Configuration: cfg_* writes field_delimiter (index 0) or quote_byte
// (index 1); other indexes are ignored. cfg_ready is always high.
// Reset: delimiter comma, quote double quote, no held byte, quote state
// cleared, result queue empty.
module csv_delimiter_marker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	output logic                                byte_stall,
	input  csvdm_pkg::csvdm_in_t                byte_word,
	output logic                                mark_valid,
	input  logic                                mark_stall,
	output csvdm_pkg::csvdm_out_t               mark_word,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [csvdm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                          cfg_data
);
	import csvdm_pkg::*;

	logic [7:0]   field_delimiter_q, quote_byte_q;
	logic         held_valid_q;
	logic [7:0]   held_byte_q;
	csvdm_state_t st_q, st_a, st_b;
	csvdm_out_t   res_held, res_last;
	csvdm_push_t  push;
	logic         accept, q_full;

	assign cfg_ready  = 1'b1;
	assign byte_stall = q_full;
	assign accept     = byte_valid && !byte_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_delimiter_q <= DELIM_RESET;
			quote_byte_q      <= QUOTE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIELD_DELIMITER: field_delimiter_q <= cfg_data;
				REG_QUOTE_BYTE:      quote_byte_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Held byte, classified with the incoming byte as lookahead
	csvdm_mark u_mark_held (
		.cur_byte        (held_byte_q),
		.next_byte       (byte_word.data_byte),
		.has_next        (1'b1),
		.last            (1'b0),
		.field_delimiter (field_delimiter_q),
		.quote_byte      (quote_byte_q),
		.st_cur          (st_q),
		.res             (res_held),
		.st_next         (st_b)
	);

	assign st_a = held_valid_q ? st_b : st_q;

	// Final byte of a stream, no lookahead
	csvdm_mark u_mark_last (
		.cur_byte        (byte_word.data_byte),
		.next_byte       (8'h00),
		.has_next        (1'b0),
		.last            (1'b1),
		.field_delimiter (field_delimiter_q),
		.quote_byte      (quote_byte_q),
		.st_cur          (st_a),
		.res             (res_last),
		.st_next         ()
	);

	// Words pushed into the result queue
	always_comb begin
		push.cnt    = 2'd0;
		push.first  = held_valid_q ? res_held : res_last;
		push.second = res_last;
		if (accept) begin
			push.cnt = 2'(held_valid_q) + 2'(byte_word.end_of_stream);
		end
	end

	// Lookahead and quote state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			st_q         <= '0;
		end else if (accept) begin
			if (byte_word.end_of_stream) begin
				held_valid_q <= 1'b0;
				st_q         <= '0;
			end else begin
				held_valid_q <= 1'b1;
				st_q         <= st_a;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !byte_word.end_of_stream) begin
			held_byte_q <= byte_word.data_byte;
		end
	end

	csvdm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop_stall (mark_stall),
		.out_valid (mark_valid),
		.out_word  (mark_word),
		.full      (q_full)
	);

	`include "csv_delimiter_marker_assert.svh"

	`CDM_ASSERT_NEXT(a_eos_clears, accept && byte_word.end_of_stream, !held_valid_q && st_q == '0, "stream end left state behind")
	`CDM_ASSERT_SAME(a_last_no_esc, mark_valid && mark_word.last_out, !mark_word.escape_quote, "final byte marked as escape")
	`CDM_ASSERT_NEXT(a_push_shows, accept && (held_valid_q || byte_word.end_of_stream), mark_valid, "released byte missing on output")

endmodule

### design/csvdm_mark.sv
// Combinational classifier for one byte given its lookahead and quote state.
module csvdm_mark (
	input  logic [7:0]            cur_byte,
	input  logic [7:0]            next_byte,
	input  logic                  has_next,
	input  logic                  last,
	input  logic [7:0]            field_delimiter,
	input  logic [7:0]            quote_byte,
	input  csvdm_pkg::csvdm_state_t st_cur,
	output csvdm_pkg::csvdm_out_t   res,
	output csvdm_pkg::csvdm_state_t st_next
);
	import csvdm_pkg::*;

	logic is_q, next_q, start, close, esc, quoted, rec, fld, crlf;

	// Quote numbering: odd quote opens unless it follows an escaping quote, even quote escapes or closes
	always_comb begin
		is_q   = (cur_byte == quote_byte);
		next_q = has_next && (next_byte == quote_byte);
		start  = is_q && !st_cur.quote_parity && !st_cur.prior_was_escape;
		esc    = is_q && st_cur.quote_parity && next_q;
		close  = is_q && st_cur.quote_parity && !next_q;
		quoted = st_cur.in_quoted_span || start;

		st_next.quote_parity     = st_cur.quote_parity ^ is_q;
		st_next.in_quoted_span   = (st_cur.in_quoted_span || start) && !close;
		st_next.prior_was_escape = esc;
	end

	// Delimiter, record and keep marks
	always_comb begin
		rec  = (cur_byte == CHAR_LF) && !quoted;
		fld  = ((cur_byte == field_delimiter) && !quoted) || rec;
		crlf = (cur_byte == CHAR_CR) && has_next && (next_byte == CHAR_LF);

		res.out_byte     = cur_byte;
		res.record_end   = rec;
		res.field_end    = fld;
		res.escape_quote = esc;
		res.keep_byte    = !(crlf || start || close);
		res.last_out     = last;
	end

endmodule

### design/csvdm_outq.sv
// Small result queue taking up to two words per cycle and giving one per cycle while pop_stall is low.
module csvdm_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  csvdm_pkg::csvdm_push_t push,
	input  logic                   pop_stall,
	output logic                   out_valid,
	output csvdm_pkg::csvdm_out_t  out_word,
	output logic                   full
);
	import csvdm_pkg::*;

	csvdm_out_t           mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 pop;

	assign out_valid = (cnt_q != '0);
	assign out_word  = mem_q[rd_ptr_q];
	assign pop       = out_valid && !pop_stall;
	// Room must remain for a two-word push
	assign full      = (cnt_q > Q_CNT_W'(Q_DEPTH - 2));

	// Storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_q + Q_PTR_W'(1)] <= push.second;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
		end
	end

endmodule

### tb/csvdm_mark_checker.sv
// Checker for the CSV delimiter marker: predicts marked words and compares them.
`timescale 1ns / 1ps

module csvdm_mark_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	input  logic                           byte_stall,
	input  csvdm_pkg::csvdm_in_t           byte_word,
	input  logic                           mark_valid,
	input  logic                           mark_stall,
	input  csvdm_pkg::csvdm_out_t          mark_word,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [csvdm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	output int                             fail_count,
	output int                             outstanding,
	output int                             marks_checked
);
	import csvdm_pkg::*;

	// Shadow copy of the registers and the tokenizer state
	logic [7:0]   delim_code;
	logic [7:0]   quote_code;
	logic         held_valid;
	logic [7:0]   held_byte;
	csvdm_state_t qs;
	csvdm_out_t   expected_marks [$];

	// Marks one byte given its lookahead byte; advances the quote state
	function automatic csvdm_out_t mark_byte(logic [7:0] b, logic [7:0] nb,
			logic has_next, logic last);
		logic       is_q;
		logic       next_q;
		logic       opens;
		logic       closes;
		logic       esc;
		logic       quoted;
		csvdm_out_t r;
		is_q   = (b == quote_code);
		next_q = has_next && (nb == quote_code);
		opens  = 1'b0;
		closes = 1'b0;
		esc    = 1'b0;
		if (is_q) begin
			if (!qs.quote_parity) begin
				opens = !qs.prior_was_escape;
			end else begin
				esc    = next_q;
				closes = !next_q;
			end
			qs.quote_parity = !qs.quote_parity;
		end
		quoted = qs.in_quoted_span || opens;
		if (opens)
			qs.in_quoted_span = 1'b1;
		if (closes)
			qs.in_quoted_span = 1'b0;
		qs.prior_was_escape = esc;

		r.out_byte     = b;
		r.record_end   = (b == CHAR_LF) && !quoted;
		r.field_end    = ((b == delim_code) && !quoted) || r.record_end;
		r.escape_quote = esc;
		r.keep_byte    = !(((b == CHAR_CR) && has_next && (nb == CHAR_LF)) || opens || closes);
		r.last_out     = last;
		return r;
	endfunction

	// Returns 1 on a mismatch
	function automatic int field_diff(string name, int unsigned want, int unsigned got);
		if (want == got)
			return 0;
		$error("mark word %0d: %s expected 0x%0h, got 0x%0h", marks_checked, name, want, got);
		return 1;
	endfunction

	// Compare accepted marks first, then predict from the accepted byte
	always @(posedge clk or negedge arst_n) begin : predict_and_check
		int         bad;
		csvdm_out_t want;
		csvdm_out_t pred;
		if (!arst_n) begin
			delim_code    = DELIM_RESET;
			quote_code    = QUOTE_RESET;
			held_valid    = 1'b0;
			held_byte     = '0;
			qs            = '0;
			expected_marks.delete();
			fail_count    <= 0;
			outstanding   <= 0;
			marks_checked <= 0;
		end else begin
			bad = 0;
			if (mark_valid && !mark_stall) begin
				marks_checked <= marks_checked + 1;
				if (expected_marks.size() == 0) begin
					bad++;
					$error("marked word 0x%0h arrived with nothing expected", mark_word);
				end else begin
					want = expected_marks.pop_front();
					bad += field_diff("out_byte", want.out_byte, mark_word.out_byte);
					bad += field_diff("record_end", want.record_end, mark_word.record_end);
					bad += field_diff("field_end", want.field_end, mark_word.field_end);
					bad += field_diff("escape_quote", want.escape_quote,
						mark_word.escape_quote);
					bad += field_diff("keep_byte", want.keep_byte, mark_word.keep_byte);
					bad += field_diff("last_out", want.last_out, mark_word.last_out);
				end
			end

			// register writes; spare indexes change nothing
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FIELD_DELIMITER: delim_code = cfg_data;
					REG_QUOTE_BYTE:      quote_code = cfg_data;
					default: ;
				endcase
			end

			// the held byte goes out once its lookahead shows up
			if (byte_valid && !byte_stall) begin
				if (held_valid) begin
					pred = mark_byte(held_byte, byte_word.data_byte, 1'b1, 1'b0);
					expected_marks.insert(expected_marks.size(), pred);
				end
				if (byte_word.end_of_stream) begin
					pred = mark_byte(byte_word.data_byte, 8'h00, 1'b0, 1'b1);
					expected_marks.insert(expected_marks.size(), pred);
					held_valid = 1'b0;
					held_byte  = '0;
					qs         = '0;
				end else begin
					held_valid = 1'b1;
					held_byte  = byte_word.data_byte;
				end
			end

			fail_count  <= fail_count + bad;
			outstanding <= expected_marks.size();
		end
	end

endmodule

### tb/tb_top.sv
// Testbench top for the CSV delimiter marker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
	import csvdm_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 8;
	// indexes past the register list, written to check they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 byte_valid = 1'b0;
	logic                 byte_stall;
	csvdm_in_t            byte_word = '0;
	logic                 mark_valid;
	logic                 mark_stall = 1'b0;
	csvdm_out_t           mark_word;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	int fail_count;
	int outstanding;
	int marks_checked;

	// stimulus bookkeeping
	logic [7:0] cur_delim = DELIM_RESET;
	logic [7:0] cur_quote = QUOTE_RESET;
	int         bytes_sent = 0;
	int         streams_ended = 0;
	int         settings_done = 0;
	int         cycles = 0;
	bit         no_idle = 1'b0;
	int         hold_asked = 0;
	int         hold_done = 0;

	csv_delimiter_marker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.mark_valid (mark_valid),
		.mark_stall (mark_stall),
		.mark_word  (mark_word),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	csvdm_mark_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.byte_word     (byte_word),
		.mark_valid    (mark_valid),
		.mark_stall    (mark_stall),
		.mark_word     (mark_word),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.marks_checked (marks_checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	// Idle lengths: mostly short, a few long
	function automatic int burst_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Receiver: random stall runs, free stretches, and the long hold-off on request
	initial begin : mark_receiver
		int run;
		bit stall_now;
		forever begin
			if (hold_asked != hold_done) begin
				mark_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end else begin
				stall_now = !no_idle && ($urandom_range(0, 2) == 0);
				if (stall_now)
					run = burst_len();
				else if ($urandom_range(0, 9) == 0)
					run = $urandom_range(40, 120);
				else
					run = $urandom_range(1, 6);
				mark_stall <= stall_now;
				repeat (run) begin
					@(posedge clk);
					if (hold_asked != hold_done || (no_idle && stall_now))
						break;
				end
			end
		end
	end

	// Offer one word and hold it until taken, then maybe go idle
	task automatic send_word(input logic [7:0] d, input logic eos);
		csvdm_in_t w;
		int        gap;
		w.data_byte     = d;
		w.end_of_stream = eos;
		byte_word  <= w;
		byte_valid <= 1'b1;
		do @(posedge clk); while (byte_stall);
		bytes_sent++;
		if (eos)
			streams_ended++;
		gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : burst_len();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s, input bit eos_last);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], eos_last && (i == s.len() - 1));
	endtask

	// Sender pause until every expected mark is back, plus the pipeline tail
	task automatic drain_marks();
		byte_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FIELD_DELIMITER: cur_delim = val;
			REG_QUOTE_BYTE:      cur_quote = val;
			default: ;
		endcase
	endtask

	// Raw byte biased toward the codes the tokenizer reacts to
	function automatic logic [7:0] noise_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return cur_quote;
		if (r < 27)
			return cur_delim;
		if (r < 35)
			return CHAR_LF;
		if (r < 42)
			return CHAR_CR;
		return 8'($urandom_range(0, 255));
	endfunction

	// Field content; quoted fields may carry delimiters, line breaks and quotes
	function automatic logic [7:0] text_byte(input bit in_quotes);
		int r;
		r = $urandom_range(0, 9);
		if (in_quotes && r == 0)
			return cur_delim;
		if (in_quotes && r == 1)
			return CHAR_LF;
		if (in_quotes && r == 2)
			return CHAR_CR;
		if (in_quotes && r == 3)
			return cur_quote;
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	// One well-formed record with random fields, LF or CRLF at its end
	task automatic send_record();
		int         nf;
		int         len;
		bit         quoted;
		logic [7:0] c;
		nf = $urandom_range(1, 4);
		for (int f = 0; f < nf; f++) begin
			quoted = ($urandom_range(0, 1) == 0);
			len    = $urandom_range(0, 6);
			if (quoted)
				send_word(cur_quote, 1'b0);
			for (int i = 0; i < len; i++) begin
				c = text_byte(quoted);
				send_word(c, 1'b0);
				if (quoted && c == cur_quote)
					send_word(c, 1'b0);
			end
			if (quoted)
				send_word(cur_quote, 1'b0);
			if (f != nf - 1)
				send_word(cur_delim, 1'b0);
		end
		if ($urandom_range(0, 1) == 0)
			send_word(CHAR_CR, 1'b0);
		send_word(CHAR_LF, $urandom_range(0, 4) == 0);
	endtask

	// Short burst of loose bytes, sometimes ending the stream
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 8);
		repeat (n)
			send_word(noise_byte(), $urandom_range(0, 9) == 0);
	endtask

	task automatic random_phase(input int n);
		int target;
		target = bytes_sent + n;
		while (bytes_sent < target) begin
			no_idle = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 3) != 0)
				send_record();
			else
				send_noise();
		end
		no_idle = 1'b0;
	endtask

	task automatic run_setting(input logic [7:0] delim, input logic [7:0] quote, input int n);
		write_reg(REG_FIELD_DELIMITER, delim);
		write_reg(REG_QUOTE_BYTE, quote);
		settings_done++;
		random_phase(n);
		drain_marks();
	endtask

	// Main sequence
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed streams at reset settings, back to back
		no_idle = 1'b1;
		send_text("\"a\"\"b\",\015\012z", 1'b1);
		send_word(8'hFF, 1'b1);
		send_word(8'h00, 1'b0);
		send_text("\015\"", 1'b1);
		send_text("\"\012,\015", 1'b1);
		send_text("\"\"\"\"\012", 1'b1);
		no_idle = 1'b0;
		random_phase(70);
		drain_marks();
		settings_done++;

		run_setting(8'h00, 8'hFF, 120);
		run_setting(8'hFF, 8'h00, 120);

		// receiver holds off while the sender keeps offering bytes
		write_reg(REG_FIELD_DELIMITER, CHAR_CR);
		write_reg(REG_QUOTE_BYTE, CHAR_LF);
		settings_done++;
		hold_asked++;
		no_idle = 1'b1;
		repeat (40)
			send_word(noise_byte(), $urandom_range(0, 9) == 0);
		no_idle = 1'b0;
		random_phase(80);
		drain_marks();

		// quote and delimiter share a code; spare indexes must not disturb it
		run_setting(8'h22, 8'h22, 60);
		write_reg(REG_SPARE_2, 8'($urandom_range(0, 255)));
		write_reg(REG_SPARE_3, 8'($urandom_range(0, 255)));
		random_phase(60);
		drain_marks();

		run_setting(8'h09, 8'h27, 120);
		run_setting(DELIM_RESET, QUOTE_RESET, 85);

		drain_marks();
		$display("tb_top: %0d bytes in %0d ended streams, %0d marked words checked",
			bytes_sent, streams_ended, marks_checked);
		$display("tb_top: %0d delimiter/quote settings incl. extremes, long receiver hold-off",
			settings_done);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/csvdm_pkg.sv
design/csvdm_mark.sv
design/csvdm_outq.sv
design/csv_delimiter_marker.sv
tb/csvdm_mark_checker.sv
tb/tb_top.sv
